[hw/rtl/afs_pkg.sv]
// afs_pkg: shared types, constants and control program of the frame sequencer
// no dependencies; used by anim_frame_sequencer_core
package afs_pkg;

  // field widths and limits
  localparam int FRAME_BITS = 16;
  localparam int STEP_BITS  = 9;
  localparam int MAX_STEP   = 255;
  localparam int CFG_IDX_W  = 3;
  localparam int MODE_W     = 2;
  localparam int PC_W       = 4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LAST_FRAME    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_ENABLE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_FROM   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_TO     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PLAY_MODE     = 3'd4;

  // play modes
  localparam logic [MODE_W-1:0] MODE_FWD = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REV = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PP  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_BAD = 2'd3;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_CLAMP,
    OP_MOD_INIT,
    OP_MOD_ABS,
    OP_MOD_STEP,
    OP_MOD_FIX,
    OP_MOD_ADD,
    OP_PP_INIT,
    OP_PP_STEP,
    OP_PP_END,
    OP_EMIT
  } uop_t;

  // jump conditions
  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_IN_WAIT,
    C_CNT_MORE,
    C_NOOP,
    C_PINGPONG,
    C_OUT_BUSY
  } cond_t;

  // control word: operation, jump condition and target, end of program
  typedef struct packed {
    uop_t            op;
    cond_t           cond;
    logic [PC_W-1:0] target;
    logic            last;
  } uword_t;

  // program addresses
  localparam logic [PC_W-1:0] A_IDLE     = 4'd0;
  localparam logic [PC_W-1:0] A_CLAMP    = 4'd1;
  localparam logic [PC_W-1:0] A_TEST     = 4'd2;
  localparam logic [PC_W-1:0] A_SEL      = 4'd3;
  localparam logic [PC_W-1:0] A_MOD_INIT = 4'd4;
  localparam logic [PC_W-1:0] A_MOD_ABS  = 4'd5;
  localparam logic [PC_W-1:0] A_MOD_STEP = 4'd6;
  localparam logic [PC_W-1:0] A_MOD_FIX  = 4'd7;
  localparam logic [PC_W-1:0] A_MOD_ADD  = 4'd8;
  localparam logic [PC_W-1:0] A_PP_INIT  = 4'd9;
  localparam logic [PC_W-1:0] A_PP_STEP  = 4'd10;
  localparam logic [PC_W-1:0] A_PP_END   = 4'd11;
  localparam logic [PC_W-1:0] A_EMIT     = 4'd12;

  // control program rom
  function automatic uword_t prog_rom(input logic [PC_W-1:0] addr);
    uword_t w;
    w = '{op: OP_NOP, cond: C_ALWAYS, target: A_IDLE, last: 1'b0};
    case (addr)
      A_IDLE:     w = '{op: OP_LOAD,     cond: C_IN_WAIT,  target: A_IDLE,     last: 1'b0};
      A_CLAMP:    w = '{op: OP_CLAMP,    cond: C_NEVER,    target: A_IDLE,     last: 1'b0};
      A_TEST:     w = '{op: OP_NOP,      cond: C_NOOP,     target: A_EMIT,     last: 1'b0};
      A_SEL:      w = '{op: OP_NOP,      cond: C_PINGPONG, target: A_PP_INIT,  last: 1'b0};
      A_MOD_INIT: w = '{op: OP_MOD_INIT, cond: C_NEVER,    target: A_IDLE,     last: 1'b0};
      A_MOD_ABS:  w = '{op: OP_MOD_ABS,  cond: C_NEVER,    target: A_IDLE,     last: 1'b0};
      A_MOD_STEP: w = '{op: OP_MOD_STEP, cond: C_CNT_MORE, target: A_MOD_STEP, last: 1'b0};
      A_MOD_FIX:  w = '{op: OP_MOD_FIX,  cond: C_NEVER,    target: A_IDLE,     last: 1'b0};
      A_MOD_ADD:  w = '{op: OP_MOD_ADD,  cond: C_ALWAYS,   target: A_EMIT,     last: 1'b0};
      A_PP_INIT:  w = '{op: OP_PP_INIT,  cond: C_NEVER,    target: A_IDLE,     last: 1'b0};
      A_PP_STEP:  w = '{op: OP_PP_STEP,  cond: C_CNT_MORE, target: A_PP_STEP,  last: 1'b0};
      A_PP_END:   w = '{op: OP_PP_END,   cond: C_NEVER,    target: A_IDLE,     last: 1'b0};
      A_EMIT:     w = '{op: OP_EMIT,     cond: C_OUT_BUSY, target: A_EMIT,     last: 1'b1};
      default:    w = '{op: OP_NOP,      cond: C_ALWAYS,   target: A_IDLE,     last: 1'b0};
    endcase
    return w;
  endfunction

endpackage

[hw/rtl/anim_frame_sequencer_core.sv]
// anim_frame_sequencer_core: microcoded frame index sequencer with stream ports
// depends on afs_pkg for constants, control word types and the program rom
//
// paths: zero step, reversed window or unused mode go from the test straight to the
// output register; forward/reverse run the bit-serial remainder loop; ping-pong
// walks the step frame by frame (one frame walked per cycle)
// throughput: one item at a time, the next one taken the cycle after the result
// register loads, also while that result waits
// reset: rst_n synchronous, clears configuration and output valid, parks the
// program at idle and sets the bounce bit forward
module anim_frame_sequencer_core #(
  parameter int FRAME_BITS = afs_pkg::FRAME_BITS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // input items
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [FRAME_BITS-1:0] current_frame, [FRAME_BITS+8:FRAME_BITS] step, zero fill
  input  logic [((FRAME_BITS+afs_pkg::STEP_BITS+7)/8)*8-1:0] in_tdata,
  // result items
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [FRAME_BITS-1:0] next_frame, [FRAME_BITS] heading_forward, zero fill
  output logic [((FRAME_BITS+1+7)/8)*8-1:0]  out_tdata,
  // configuration writes
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [afs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [FRAME_BITS-1:0]              cfg_data
);

  localparam int SB     = afs_pkg::STEP_BITS;
  localparam int OUT_W  = ((FRAME_BITS + 1 + 7) / 8) * 8;
  // signed width holding frame + step - first
  localparam int VW     = ((FRAME_BITS > SB) ? FRAME_BITS : SB) + 2;
  localparam int PC_W   = afs_pkg::PC_W;
  localparam int MW     = afs_pkg::MODE_W;

  // configuration registers
  logic [FRAME_BITS-1:0] last_frame_r;
  logic                  window_enable_r;
  logic [FRAME_BITS-1:0] window_from_r;
  logic [FRAME_BITS-1:0] window_to_r;
  logic [MW-1:0]         play_mode_r;

  // sequencer and datapath registers
  logic [PC_W-1:0]       pc_r, pc_nxt;
  logic                  dir_r, dir_nxt;
  logic [FRAME_BITS-1:0] frame_r, frame_nxt;
  logic [SB-1:0]         mag_r, mag_nxt;
  logic                  neg_r, neg_nxt;
  logic [FRAME_BITS-1:0] first_r, first_nxt;
  logic [FRAME_BITS-1:0] last_r, last_nxt;
  logic [MW-1:0]         mode_r, mode_nxt;
  logic [FRAME_BITS:0]   range_r, range_nxt;
  logic [VW-1:0]         acc_r, acc_nxt;
  logic                  vneg_r, vneg_nxt;
  logic [FRAME_BITS:0]   rem_r, rem_nxt;
  logic [SB-1:0]         cnt_r, cnt_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [FRAME_BITS-1:0] out_frame_r, out_frame_nxt;
  logic                  out_head_r, out_head_nxt;

  afs_pkg::uword_t       uw;

  // input field views
  logic [FRAME_BITS-1:0] in_frame;
  logic [SB-1:0]         in_step;
  logic [SB-1:0]         in_mag;
  logic                  in_take;
  logic                  out_free;

  // datapath helpers
  logic                  eff_neg;
  logic [VW-1:0]         sdelta;
  logic [FRAME_BITS+1:0] trial;
  logic                  cond_hit;

  assign cfg_ready = 1'b1;
  assign in_tready = (pc_r == afs_pkg::A_IDLE);
  assign in_take   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'({out_head_r, out_frame_r});

  assign in_frame = in_tdata[FRAME_BITS-1:0];
  assign in_step  = in_tdata[FRAME_BITS+SB-1:FRAME_BITS];
  assign uw       = afs_pkg::prog_rom(pc_r);

  // step magnitude, saturated to the step limit
  always_comb begin
    logic [SB-1:0] m;
    m = in_step[SB-1] ? (~in_step + SB'(1)) : in_step;
    in_mag = (32'(m) > afs_pkg::MAX_STEP) ? SB'(afs_pkg::MAX_STEP) : m;
  end

  // signed move for forward and reverse wrap
  assign eff_neg = neg_r ^ (mode_r == afs_pkg::MODE_REV);
  assign sdelta  = eff_neg ? (VW'(0) - VW'(mag_r)) : VW'(mag_r);
  assign trial   = {rem_r, acc_r[VW-2]};

  // jump condition select
  always_comb begin
    case (uw.cond)
      afs_pkg::C_NEVER:    cond_hit = 1'b0;
      afs_pkg::C_ALWAYS:   cond_hit = 1'b1;
      afs_pkg::C_IN_WAIT:  cond_hit = !in_take;
      afs_pkg::C_CNT_MORE: cond_hit = (cnt_r != SB'(1));
      afs_pkg::C_NOOP:     cond_hit = (mag_r == '0) || (first_r > last_r) ||
                                      (mode_r == afs_pkg::MODE_BAD);
      afs_pkg::C_PINGPONG: cond_hit = (mode_r == afs_pkg::MODE_PP);
      afs_pkg::C_OUT_BUSY: cond_hit = !out_free;
      default:             cond_hit = 1'b0;
    endcase
  end

  // sequencing
  always_comb begin
    if (cond_hit) begin
      pc_nxt = uw.target;
    end else if (uw.last) begin
      pc_nxt = afs_pkg::A_IDLE;
    end else begin
      pc_nxt = pc_r + PC_W'(1);
    end
  end

  // datapath driven by the control word
  always_comb begin
    dir_nxt       = dir_r;
    frame_nxt     = frame_r;
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    first_nxt     = first_r;
    last_nxt      = last_r;
    mode_nxt      = mode_r;
    range_nxt     = range_r;
    acc_nxt       = acc_r;
    vneg_nxt      = vneg_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_frame_nxt = out_frame_r;
    out_head_nxt  = out_head_r;
    case (uw.op)
      afs_pkg::OP_LOAD: begin
        if (in_take) begin
          frame_nxt = in_frame;
          mag_nxt   = in_mag;
          neg_nxt   = in_step[SB-1];
        end
      end
      afs_pkg::OP_CLAMP: begin
        if (window_enable_r) begin
          first_nxt = (window_from_r > last_frame_r) ? last_frame_r : window_from_r;
          last_nxt  = (window_to_r > last_frame_r) ? last_frame_r : window_to_r;
          mode_nxt  = play_mode_r;
        end else begin
          first_nxt = '0;
          last_nxt  = last_frame_r;
          mode_nxt  = afs_pkg::MODE_FWD;
        end
      end
      afs_pkg::OP_MOD_INIT: begin
        acc_nxt   = VW'(frame_r) + sdelta - VW'(first_r);
        range_nxt = {1'b0, last_r} - {1'b0, first_r} + (FRAME_BITS+1)'(1);
      end
      afs_pkg::OP_MOD_ABS: begin
        vneg_nxt = acc_r[VW-1];
        acc_nxt  = acc_r[VW-1] ? (VW'(0) - acc_r) : acc_r;
        rem_nxt  = '0;
        cnt_nxt  = SB'(VW - 1);
      end
      afs_pkg::OP_MOD_STEP: begin
        // one restoring remainder bit
        if (trial >= {1'b0, range_r}) begin
          rem_nxt = (FRAME_BITS+1)'(trial - {1'b0, range_r});
        end else begin
          rem_nxt = trial[FRAME_BITS:0];
        end
        acc_nxt = acc_r << 1;
        cnt_nxt = cnt_r - SB'(1);
      end
      afs_pkg::OP_MOD_FIX: begin
        if (vneg_r && (rem_r != '0)) begin
          rem_nxt = range_r - rem_r;
        end
      end
      afs_pkg::OP_MOD_ADD: begin
        frame_nxt = first_r + rem_r[FRAME_BITS-1:0];
      end
      afs_pkg::OP_PP_INIT: begin
        if (neg_r) begin
          dir_nxt = !dir_r;
        end
        cnt_nxt = mag_r;
      end
      afs_pkg::OP_PP_STEP: begin
        // walk one frame, bounce at the window ends
        if (dir_r) begin
          if (frame_r >= last_r) begin
            frame_nxt = (last_r > first_r) ? (last_r - FRAME_BITS'(1)) : first_r;
            dir_nxt   = 1'b0;
          end else begin
            frame_nxt = frame_r + FRAME_BITS'(1);
          end
        end else begin
          if (frame_r <= first_r) begin
            frame_nxt = (first_r < last_r) ? (first_r + FRAME_BITS'(1)) : last_r;
            dir_nxt   = 1'b1;
          end else begin
            frame_nxt = frame_r - FRAME_BITS'(1);
          end
        end
        cnt_nxt = cnt_r - SB'(1);
      end
      afs_pkg::OP_PP_END: begin
        if (neg_r) begin
          dir_nxt = !dir_r;
        end
      end
      afs_pkg::OP_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_frame_nxt = frame_r;
          out_head_nxt  = dir_r;
        end
      end
      default: begin
      end
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_frame_r    <= '0;
      window_enable_r <= 1'b0;
      window_from_r   <= '0;
      window_to_r     <= '0;
      play_mode_r     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        afs_pkg::REG_LAST_FRAME:    last_frame_r    <= cfg_data;
        afs_pkg::REG_WINDOW_ENABLE: window_enable_r <= cfg_data[0];
        afs_pkg::REG_WINDOW_FROM:   window_from_r   <= cfg_data;
        afs_pkg::REG_WINDOW_TO:     window_to_r     <= cfg_data;
        afs_pkg::REG_PLAY_MODE:     play_mode_r     <= cfg_data[MW-1:0];
        default: begin
        end
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= afs_pkg::A_IDLE;
      dir_r       <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      pc_r        <= pc_nxt;
      dir_r       <= dir_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    frame_r     <= frame_nxt;
    mag_r       <= mag_nxt;
    neg_r       <= neg_nxt;
    first_r     <= first_nxt;
    last_r      <= last_nxt;
    mode_r      <= mode_nxt;
    range_r     <= range_nxt;
    acc_r       <= acc_nxt;
    vneg_r      <= vneg_nxt;
    rem_r       <= rem_nxt;
    cnt_r       <= cnt_nxt;
    out_frame_r <= out_frame_nxt;
    out_head_r  <= out_head_nxt;
  end

endmodule
